FILE: rtl/adaptive_threshold_r_peak_detector_assert.svh
// Assertion macros used by the detector top level.
`ifndef ADAPTIVE_THRESHOLD_R_PEAK_DETECTOR_ASSERT_SVH
`define ADAPTIVE_THRESHOLD_R_PEAK_DETECTOR_ASSERT_SVH

// Clocked assertion that is disabled while reset is held.
`define ATRPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication, disabled while reset is held.
`define ATRPD_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

FILE: rtl/atrpd_pkg.sv
// Package with shared constants of the R-peak detector.
package atrpd_pkg;

  // Counter and ring geometry
  localparam int CNT_W            = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int RR_DEPTH         = 8;
  localparam int RR_IDX_W         = $clog2(RR_DEPTH);
  localparam int RR_SUM_W         = CNT_W + RR_IDX_W;
  localparam int HEIGHT_DEPTH     = 5;
  localparam int HIDX_W           = $clog2(HEIGHT_DEPTH);
  localparam int PEAK_ADAPT_MIN   = HEIGHT_DEPTH - 1;
  localparam int THR_GAIN         = 44 / (HEIGHT_DEPTH - 1);
  localparam int THR_EXTRA_W      = 8;

  // Sample and index widths
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int PEAK_IDX_W       = 32;

  // Configuration port
  localparam int REFR_W           = 12;
  localparam int RRI_W            = 14;
  localparam int CFG_W            = 14;
  localparam int CFG_IDX_W        = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RR_INITIAL = 1'd1;
  localparam logic [REFR_W-1:0] REFR_RESET = 12'd72;
  localparam logic [RRI_W-1:0]  RRI_RESET  = 14'd252;

  // Opcodes
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_PRIME = 2'd0;
  localparam logic [OP_W-1:0] OP_ECG   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

endpackage

FILE: rtl/adaptive_threshold_r_peak_detector.sv
// Adaptive-threshold R-peak detector, top level.
//
// Takes one transaction per clock: each item (prime, ECG sample or end of segment) is
// processed in the cycle it is accepted and any finished peak appears in the output
// register on the next cycle. in_ready_o is low only while a peak is held in the output
// register and out_ready_i is low, so the sustained rate is one item per cycle, set by
// the single state update path (compare against the threshold, peak/RR update and the
// five-entry threshold sum). The RR mean is kept as a running sum, so no sweep is needed
// at arming, and there is no clearing pass after reset.
module adaptive_threshold_r_peak_detector #(
  parameter int SAMPLE_BITS = atrpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [atrpd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [atrpd_pkg::CFG_W-1:0]            cfg_wdata_i,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [atrpd_pkg::OP_W-1:0]             opcode_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [atrpd_pkg::PEAK_IDX_W-1:0]       peak_index_o,
  output logic signed [SAMPLE_BITS-1:0]          peak_amplitude_o
);
  import atrpd_pkg::*;

`include "adaptive_threshold_r_peak_detector_assert.svh"

  localparam int THR_W = SAMPLE_BITS + THR_EXTRA_W;
  localparam int CMP_W = RR_SUM_W + 5;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers
  logic [REFR_W-1:0] refr_q;
  logic [RRI_W-1:0]  rr_init_q;

  // Segment state
  logic                          armed_q, armed_d;
  logic signed [SAMPLE_BITS-1:0] env_q, env_d;
  logic signed [THR_W-1:0]       thr_q, thr_d;
  logic [CNT_W-1:0]              rr_q [RR_DEPTH];
  logic [CNT_W-1:0]              rr_d [RR_DEPTH];
  logic [RR_SUM_W-1:0]           rr_sum_q, rr_sum_d;
  logic signed [SAMPLE_BITS-1:0] hgt_q [HEIGHT_DEPTH];
  logic signed [SAMPLE_BITS-1:0] hgt_d [HEIGHT_DEPTH];
  logic [HIDX_W-1:0]             hidx_q, hidx_d;
  logic [CNT_W-1:0]              pc_q, pc_d;
  logic [CNT_W-1:0]              cur_pos_q, cur_pos_d;
  logic [CNT_W-1:0]              prev_q, prev_d;
  logic signed [SAMPLE_BITS-1:0] cur_val_q, cur_val_d;
  logic [CNT_W-1:0]              lidx_q, lidx_d;
  logic [PEAK_IDX_W-1:0]         base_q, base_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [PEAK_IDX_W-1:0]         out_idx_q, out_idx_d;
  logic signed [SAMPLE_BITS-1:0] out_amp_q, out_amp_d;

  logic                          in_fire;
  logic signed [THR_W-1:0]       thr_adapt;
  logic signed [THR_W-1:0]       thr_cur;

  assign in_ready_o       = !out_valid_q || out_ready_i;
  assign in_fire          = in_valid_i && in_ready_o;
  assign out_valid_o      = out_valid_q;
  assign peak_index_o     = out_idx_q;
  assign peak_amplitude_o = out_amp_q;

  // Threshold from the next height ring
  atrpd_thr_calc #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_thr_calc (
    .heights_i(hgt_d),
    .thr_o    (thr_adapt)
  );

  // Per-item state update
  always_comb begin
    logic signed [THR_W-1:0]       x_ext;
    logic signed [THR_W-1:0]       x80;
    logic [CNT_W-1:0]              rr_b [RR_DEPTH];
    logic [RR_SUM_W-1:0]           rr_sum_b;
    logic signed [SAMPLE_BITS-1:0] hgt_b [HEIGHT_DEPTH];
    logic [HIDX_W-1:0]             hidx_b;
    logic [CNT_W-1:0]              pc_b;
    logic [CNT_W-1:0]              cur_pos_b;
    logic [CNT_W-1:0]              prev_b;
    logic signed [SAMPLE_BITS-1:0] cur_val_b;
    logic [CNT_W-1:0]              gap;
    logic [CMP_W-1:0]              gap160;
    logic [CMP_W-1:0]              sum11;
    logic                          pass;
    logic                          near;
    logic                          new_peak;
    logic                          move;
    logic                          pc_inc;
    logic                          emit;
    logic [RR_IDX_W-1:0]           rr_idx;
    logic [CNT_W-1:0]              rr_new;

    // defaults: hold everything
    armed_d     = armed_q;
    env_d       = env_q;
    rr_d        = rr_q;
    rr_sum_d    = rr_sum_q;
    hgt_d       = hgt_q;
    hidx_d      = hidx_q;
    pc_d        = pc_q;
    cur_pos_d   = cur_pos_q;
    prev_d      = prev_q;
    cur_val_d   = cur_val_q;
    lidx_d      = lidx_q;
    base_d      = base_q;
    out_idx_d   = out_idx_q;
    out_amp_d   = out_amp_q;
    emit        = 1'b0;

    x_ext  = THR_W'(sample_i);
    x80    = (x_ext <<< 6) + (x_ext <<< 4);

    // Arming view: the first ECG sample sees freshly loaded state
    thr_cur   = armed_q ? thr_q : (THR_W'(env_q) <<< 6);
    rr_sum_b  = armed_q ? rr_sum_q : (RR_SUM_W'(rr_init_q) << RR_IDX_W);
    hidx_b    = armed_q ? hidx_q : HIDX_W'(1);
    pc_b      = armed_q ? pc_q : CNT_W'(1);
    cur_pos_b = armed_q ? cur_pos_q : '0;
    prev_b    = armed_q ? prev_q : '0;
    cur_val_b = armed_q ? cur_val_q : sample_i;
    for (int j = 0; j < RR_DEPTH; j++) begin
      rr_b[j] = armed_q ? rr_q[j] : CNT_W'(rr_init_q);
    end
    for (int j = 0; j < HEIGHT_DEPTH; j++) begin
      hgt_b[j] = armed_q ? hgt_q[j] : '0;
    end

    // Peak decision
    gap      = lidx_q - cur_pos_b;
    gap160   = (CMP_W'(gap) << 7) + (CMP_W'(gap) << 5);
    sum11    = (CMP_W'(rr_sum_b) << 3) + (CMP_W'(rr_sum_b) << 1) + CMP_W'(rr_sum_b);
    pass     = x80 > thr_cur;
    near     = (gap <= CNT_W'(refr_q)) || (gap160 <= sum11);
    new_peak = pass && !near;
    move     = pass && near && (sample_i > cur_val_b);
    pc_inc   = new_peak && (pc_b != CNT_MAX);
    rr_idx   = '0;
    rr_new   = '0;

    if (in_fire) begin
      case (opcode_i)
        OP_PRIME: begin
          if (!armed_q && (sample_i > env_q)) begin
            env_d = sample_i;
          end
        end
        OP_ECG: begin
          armed_d   = 1'b1;
          emit      = new_peak && !((pc_b == CNT_W'(1)) && (cur_pos_b == '0));
          out_idx_d = base_q + PEAK_IDX_W'(cur_pos_b);
          out_amp_d = cur_val_b;
          pc_d      = pc_inc ? pc_b + CNT_W'(1) : pc_b;
          if (pc_inc) begin
            hidx_d = (hidx_b == HIDX_W'(HEIGHT_DEPTH - 1)) ? '0 : hidx_b + HIDX_W'(1);
          end else begin
            hidx_d = hidx_b;
          end
          prev_d    = new_peak ? cur_pos_b : prev_b;
          cur_pos_d = (new_peak || move) ? lidx_q : cur_pos_b;
          cur_val_d = (new_peak || move) ? sample_i : cur_val_b;
          hgt_d     = hgt_b;
          if (new_peak || move) begin
            hgt_d[hidx_d] = sample_i;
          end
          // RR ring and running sum
          rr_d     = rr_b;
          rr_sum_d = rr_sum_b;
          rr_idx   = pc_d[RR_IDX_W-1:0];
          rr_new   = cur_pos_d - prev_d;
          if (pass && (pc_d > CNT_W'(1))) begin
            rr_d[rr_idx] = rr_new;
            rr_sum_d     = rr_sum_b - RR_SUM_W'(rr_b[rr_idx]) + RR_SUM_W'(rr_new);
          end
          lidx_d = (lidx_q != CNT_MAX) ? lidx_q + CNT_W'(1) : lidx_q;
        end
        OP_FLUSH: begin
          emit      = armed_q && !((pc_q == CNT_W'(1)) && (cur_pos_q == '0));
          out_idx_d = base_q + PEAK_IDX_W'(cur_pos_q);
          out_amp_d = cur_val_q;
          base_d    = base_q + PEAK_IDX_W'(lidx_q);
          armed_d   = 1'b0;
          env_d     = SAMPLE_MIN;
          lidx_d    = '0;
        end
        default: begin
        end
      endcase
    end

    // Output register: a new transaction replaces a drained or empty slot
    if (in_fire) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Threshold for the next item: adaptive once enough peaks exist
  always_comb begin
    thr_d = thr_q;
    if (in_fire && (opcode_i == OP_ECG)) begin
      thr_d = (pc_d > CNT_W'(PEAK_ADAPT_MIN)) ? thr_adapt : thr_cur;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refr_q      <= REFR_RESET;
      rr_init_q   <= RRI_RESET;
      armed_q     <= 1'b0;
      env_q       <= SAMPLE_MIN;
      hidx_q      <= HIDX_W'(1);
      pc_q        <= CNT_W'(1);
      cur_pos_q   <= '0;
      prev_q      <= '0;
      lidx_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REFRACTORY: refr_q    <= cfg_wdata_i[REFR_W-1:0];
          CFG_RR_INITIAL: rr_init_q <= cfg_wdata_i[RRI_W-1:0];
          default: begin
          end
        endcase
      end
      armed_q     <= armed_d;
      env_q       <= env_d;
      hidx_q      <= hidx_d;
      pc_q        <= pc_d;
      cur_pos_q   <= cur_pos_d;
      prev_q      <= prev_d;
      lidx_q      <= lidx_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    thr_q     <= thr_d;
    rr_q      <= rr_d;
    rr_sum_q  <= rr_sum_d;
    hgt_q     <= hgt_d;
    cur_val_q <= cur_val_d;
    out_idx_q <= out_idx_d;
    out_amp_q <= out_amp_d;
  end

  // Checks
  `ATRPD_ASSERT(a_pc_nonzero, pc_q != '0, "peak count dropped to zero")
  `ATRPD_ASSERT(a_hidx_range, hidx_q < HIDX_W'(HEIGHT_DEPTH), "height ring index out of range")
  `ATRPD_ASSERT_IMP(a_prev_le_cur, armed_q, prev_q <= cur_pos_q, "previous peak after current")
  `ATRPD_ASSERT_IMP(a_cur_le_idx, armed_q, cur_pos_q <= lidx_q, "peak beyond local index")
  `ATRPD_ASSERT_IMP(a_out_rise, $rose(out_valid_q), $past(in_fire), "result without transaction")

endmodule

FILE: rtl/atrpd_thr_calc.sv
// Adaptive threshold: gain times (sum of the height ring minus its largest entry).
module atrpd_thr_calc #(
  parameter int SAMPLE_BITS = atrpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] heights_i [atrpd_pkg::HEIGHT_DEPTH],
  output logic signed [SAMPLE_BITS+atrpd_pkg::THR_EXTRA_W-1:0] thr_o
);
  import atrpd_pkg::*;

  localparam int THR_W = SAMPLE_BITS + THR_EXTRA_W;
  localparam int SUM_W = SAMPLE_BITS + 3;
  localparam logic signed [THR_W-1:0] GAIN = THR_W'(THR_GAIN);

  logic signed [SUM_W-1:0] sum;
  logic signed [SAMPLE_BITS-1:0] mx;
  logic signed [SUM_W-1:0] diff;

  // Sum and maximum over the ring
  always_comb begin
    sum = '0;
    mx  = heights_i[0];
    for (int j = 0; j < HEIGHT_DEPTH; j++) begin
      sum = sum + SUM_W'(heights_i[j]);
      if (heights_i[j] > mx) begin
        mx = heights_i[j];
      end
    end
    diff = sum - SUM_W'(mx);
  end

  assign thr_o = THR_W'(THR_W'(diff) * GAIN);

endmodule

FILE: dv/rpeak_tb_pkg.sv
// Scoreboard class for the R-peak detector testbench: peak prediction and checking.
package rpeak_tb_pkg;
  import atrpd_pkg::*;

  // Threshold arithmetic, all scaled by 80
  localparam int  THR_SCALE   = 80;
  localparam int  ARM_GAIN    = 64;
  localparam int  RR_TEST_DEN = 20 * RR_DEPTH;
  localparam int  RR_TEST_NUM = 11;

  typedef struct packed {
    logic [PEAK_IDX_W-1:0]             abs_idx;
    logic signed [SAMPLE_BITS_DEF-1:0] amp;
  } peak_t;

  class peak_checker;
    int unsigned           refractory;
    int unsigned           rr_init;
    int                    env_max;
    bit                    armed;
    longint                thr_scaled;
    int unsigned           rr_ring [RR_DEPTH];
    int                    heights [HEIGHT_DEPTH];
    int unsigned           n_peaks;
    int unsigned           cur_pos;
    int unsigned           prev_pos;
    int unsigned           local_idx;
    int                    cur_val;
    logic [PEAK_IDX_W-1:0] seg_base;
    peak_t                 expected_peaks [$];
    int                    errors;
    int                    n_checked;

    function new();
      refractory = REFR_RESET;
      rr_init    = RRI_RESET;
      seg_base   = '0;
      errors     = 0;
      n_checked  = 0;
      restart_segment();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      if (idx == CFG_REFRACTORY) refractory = val & ((1 << REFR_W) - 1);
      else if (idx == CFG_RR_INITIAL) rr_init = val & ((1 << RRI_W) - 1);
    endfunction

    // RR entries back to the initial interval, heights cleared, dummy peak open
    function void clear_rings();
      foreach (rr_ring[j]) rr_ring[j] = rr_init;
      foreach (heights[j]) heights[j] = 0;
      n_peaks  = 1;
      cur_pos  = 0;
      prev_pos = 0;
    endfunction

    function void restart_segment();
      env_max    = -(1 << (SAMPLE_BITS_DEF - 1));
      armed      = 1'b0;
      thr_scaled = 0;
      clear_rings();
      cur_val    = 0;
      local_idx  = 0;
    endfunction

    // The untouched dummy at local index 0 is never reported
    function void queue_pending();
      peak_t p;
      if (n_peaks == 1 && cur_pos == 0) return;
      p.abs_idx = seg_base + cur_pos;
      p.amp     = cur_val[SAMPLE_BITS_DEF-1:0];
      expected_peaks = {expected_peaks, p};
    endfunction

    function void log_interval();
      int unsigned d;
      if (n_peaks <= 1) return;
      d = cur_pos - prev_pos;
      rr_ring[n_peaks % RR_DEPTH] = (d > CNT_MAX) ? CNT_MAX : d;
    endfunction

    function void ecg_sample(int x);
      int unsigned gap;
      longint      rr_sum;
      longint      h_sum;
      int          h_max;
      bit          near;
      // first ECG sample arms the segment
      if (!armed) begin
        armed      = 1'b1;
        thr_scaled = ARM_GAIN * longint'(env_max);
        clear_rings();
        cur_val    = x;
      end
      gap = local_idx - cur_pos;
      if (gap > CNT_MAX) gap = CNT_MAX;
      rr_sum = 0;
      foreach (rr_ring[j]) rr_sum += rr_ring[j];
      // above threshold: either move the current peak or open a new one
      if (THR_SCALE * longint'(x) > thr_scaled) begin
        near = (gap <= refractory) ||
               (longint'(RR_TEST_DEN) * longint'(gap) <= RR_TEST_NUM * rr_sum);
        if (near) begin
          if (x > cur_val) begin
            cur_pos = local_idx;
            cur_val = x;
            heights[n_peaks % HEIGHT_DEPTH] = x;
          end
          log_interval();
        end else begin
          queue_pending();
          prev_pos = cur_pos;
          if (n_peaks < CNT_MAX) n_peaks++;
          cur_pos = local_idx;
          cur_val = x;
          heights[n_peaks % HEIGHT_DEPTH] = x;
          log_interval();
        end
      end
      // adaptive threshold once enough peaks exist
      if (n_peaks > PEAK_ADAPT_MIN) begin
        h_sum = 0;
        h_max = heights[0];
        foreach (heights[j]) begin
          h_sum += heights[j];
          if (heights[j] > h_max) h_max = heights[j];
        end
        thr_scaled = THR_GAIN * (h_sum - h_max);
      end
      if (local_idx < CNT_MAX) local_idx++;
    endfunction

    // Called for every accepted input transaction
    function void accept_item(logic [OP_W-1:0] op, logic signed [SAMPLE_BITS_DEF-1:0] s);
      int x;
      x = s;
      case (op)
        OP_PRIME: if (!armed && x > env_max) env_max = x;
        OP_ECG:   ecg_sample(x);
        OP_FLUSH: begin
          queue_pending();
          seg_base += local_idx;
          restart_segment();
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // Called for every accepted output transaction
    task match_peak(logic [PEAK_IDX_W-1:0] idx, logic signed [SAMPLE_BITS_DEF-1:0] amp);
      peak_t want;
      n_checked++;
      if (expected_peaks.size() == 0) begin
        report($sformatf("unexpected peak at index %0d amplitude %0d", idx, amp));
        return;
      end
      want = expected_peaks.pop_front();
      if (idx !== want.abs_idx)
        report($sformatf("peak index %0d, expected %0d", idx, want.abs_idx));
      if (amp !== want.amp)
        report($sformatf("peak amplitude %0d, expected %0d at index %0d",
                         amp, want.amp, want.abs_idx));
    endtask
  endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench of the adaptive-threshold R-peak detector.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import atrpd_pkg::*;
  import rpeak_tb_pkg::*;

  localparam int SW             = SAMPLE_BITS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int DRAIN_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 4;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = '0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [OP_W-1:0]         opcode_i    = '0;
  logic signed [SW-1:0]    sample_i    = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [PEAK_IDX_W-1:0]   peak_index_o;
  logic signed [SW-1:0]    peak_amplitude_o;

  // receiver control, changed only by nonblocking writes at the clock edge
  logic rx_hold_req = 1'b0;
  logic quiet       = 1'b0;

  peak_checker sb;
  int          n_items    = 0;
  int          n_segments = 0;
  int          n_settings = 0;
  int          idle_pct   = 30;
  bit          no_idle    = 1'b0;

  adaptive_threshold_r_peak_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .peak_index_o     (peak_index_o),
    .peak_amplitude_o (peak_amplitude_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Output ready: random bursts, one long hold-off, always ready when quiet
  initial begin
    int run_left;
    bit hold_taken;
    run_left   = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        run_left   = RX_HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (quiet || $urandom_range(0, 99) < 60) begin
        out_ready_i <= 1'b1;
        run_left = quiet ? 0 : $urandom_range(0, 24);
      end else begin
        out_ready_i <= 1'b0;
        run_left = $urandom_range(0, 6);
      end
    end
  end

  // Output monitor: sampled mid-cycle, the transaction completes at the next edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.match_peak(peak_index_o, peak_amplitude_o);
    end
  end

  // One input transaction, followed by an optional idle burst
  task automatic send_item(logic [OP_W-1:0] op, logic signed [SW-1:0] s);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    sample_i   <= s;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.accept_item(op, s);
    if (op != OP_UNUSED) n_items++;
    if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Stop sending, wait for every predicted peak, then let the pipeline settle
  task automatic settle_peaks();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_peaks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.expected_peaks.size() != 0) begin
      sb.report($sformatf("%0d predicted peaks never arrived", sb.expected_peaks.size()));
      sb.expected_peaks.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both registers, back to back; only while idle
  task automatic load_settings(int unsigned refr, int unsigned rri);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_REFRACTORY;
    cfg_wdata_i <= CFG_W'(refr);
    sb.write_reg(CFG_REFRACTORY, refr);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RR_INITIAL;
    cfg_wdata_i <= CFG_W'(rri);
    sb.write_reg(CFG_RR_INITIAL, rri);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  // Synthetic ECG segment: priming, spiky beats with shoulders, baseline noise
  task automatic run_segment(int n_ecg, int spacing);
    int amp_ref;
    int n_prime;
    int next_peak;
    int last_peak;
    int v;
    amp_ref   = $urandom_range(200, 20000);
    n_prime   = $urandom_range(0, 4);
    idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : 20;
    for (int k = 0; k < n_prime; k++) begin
      v = (k == 0) ? amp_ref : int'($urandom_range(0, amp_ref)) - amp_ref / 2;
      send_item(OP_PRIME, SW'(v));
    end
    next_peak = $urandom_range(0, spacing);
    last_peak = -10;
    for (int i = 0; i < n_ecg; i++) begin
      // occasional stray transaction of any opcode
      if ($urandom_range(0, 99) < 3) send_item(OP_W'($urandom_range(0, 3)), SW'($urandom));
      if (i == next_peak) begin
        v = amp_ref + int'($urandom_range(0, amp_ref / 2));
        last_peak = i;
        next_peak = i + spacing + int'($urandom_range(0, 8));
      end else if (i == last_peak + 1) begin
        v = (amp_ref * 9) / 10 + int'($urandom_range(0, amp_ref / 3));
      end else if ($urandom_range(0, 99) < 4) begin
        v = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        v = int'($urandom_range(0, amp_ref / 2)) - amp_ref / 4;
      end
      if (v > 32767) v = 32767;
      send_item(OP_ECG, SW'(v));
    end
    if ($urandom_range(0, 9) != 0) send_item(OP_FLUSH, SW'($urandom));
    n_segments++;
  endtask

  // One register setting and a batch of segments under it
  task automatic run_phase(int unsigned refr, int unsigned rri, int budget,
                           int min_len, int max_len, bit hold_rx, bit calm);
    int base;
    int stop_at;
    settle_peaks();
    load_settings(refr, rri);
    if (hold_rx) rx_hold_req <= 1'b1;
    if (calm) begin
      quiet <= 1'b1;
      no_idle = 1'b1;
    end
    base = (refr > (11 * rri) / 20) ? refr : (11 * rri) / 20;
    if (base > 200) base = 200;
    stop_at = n_items + budget;
    while (n_items < stop_at)
      run_segment($urandom_range(min_len, max_len), base + 1 + $urandom_range(0, 10));
  endtask

  // Main sequence
  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, empty segment, unknown opcode, no priming,
    // priming after arming, moved dummy, extreme samples
    n_settings++;
    send_item(OP_FLUSH,  16'sh0000);
    send_item(OP_UNUSED, 16'sh7fff);
    send_item(OP_ECG,    16'sh8000);
    send_item(OP_ECG,    16'sh7fff);
    send_item(OP_PRIME,  16'sh7fff);
    send_item(OP_ECG,    16'sh0000);
    send_item(OP_FLUSH,  16'sh5a5a);
    send_item(OP_PRIME,  16'sh8000);
    send_item(OP_PRIME,  16'sh7fff);
    send_item(OP_ECG,    16'sd100);
    send_item(OP_ECG,    16'sh7fff);
    send_item(OP_FLUSH,  16'sh0000);

    // directed: zero spacing, every rise is a new peak, threshold adapts
    settle_peaks();
    load_settings(0, 0);
    send_item(OP_PRIME,  16'sd1000);
    send_item(OP_ECG,    16'sd2000);
    send_item(OP_ECG,    16'sd1500);
    send_item(OP_ECG,    16'sd3000);
    send_item(OP_UNUSED, 16'sh8000);
    send_item(OP_ECG,    16'sd1200);
    send_item(OP_ECG,    -16'sd5);
    send_item(OP_ECG,    16'sd2500);
    send_item(OP_ECG,    16'sd1800);
    send_item(OP_ECG,    16'sd100);
    send_item(OP_FLUSH,  16'shffff);

    // random phases over several settings
    run_phase(4095, 16383, 120, 10, 60, 1'b0, 1'b0);
    run_phase(0, 0, 130, 8, 50, 1'b0, 1'b0);
    run_phase(8, 20, 150, 20, 80, 1'b1, 1'b0);
    run_phase(REFR_RESET, RRI_RESET, 130, 120, 200, 1'b0, 1'b0);
    run_phase($urandom_range(0, 30), $urandom_range(0, 60), 130, 10, 60, 1'b0, 1'b1);
    settle_peaks();

    $display("Covered %0d input transactions in %0d segments under %0d register settings.",
             n_items, n_segments, n_settings);
    $display("Checked %0d output peaks, %0d mismatches.", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
